@@ rtl/core/indexed_ready_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Indexed ready queue assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_READY_QUEUE_MACROS_SVH
`define INDEXED_READY_QUEUE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define IRQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a consequence holds whenever its antecedent holds.
`define IRQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/irq_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed ready queue package
// Opcodes, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package irq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_ERASE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE     = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_NOEFFECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_EXEC   = 2'd1,
    ST_LINK   = 2'd2,
    ST_UNLINK = 2'd3
  } state_t;

endpackage

@@ rtl/core/irq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module irq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/indexed_ready_queue.sv @@
// ----------------------------------------------------------------------------
// Indexed ready queue
// FIFO of pending events keyed by handle, kept as a circular doubly linked
// ring in RAM, with push, pop, erase and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Issue an item by raising start with in_opcode, in_handle and
//   in_event_mask while busy is low; the item is taken at that edge.
//   Exactly one result follows: out_valid is high for one cycle with
//   out_status, out_handle, out_event and out_queue_empty.
//   The result is registered out of ST_EXEC for clear, pops on an empty
//   queue, refused items and pushes into an empty queue or of a queued
//   handle; a push onto a nonempty queue passes through ST_LINK first, and
//   a pop or erase that takes an entry out through ST_UNLINK. busy drops in
//   the cycle the result is shown, so a new item can be taken then; the
//   extra states serve the registered link RAM read and single write port.
//   Link and event RAMs are never cleared; per-handle queued flags, head,
//   tail and the nonempty flag live in flops and reset at once, so the
//   block takes items in the first cycle after reset.
//   The receiver cannot stall: each result is taken as it is shown.
// ----------------------------------------------------------------------------
`include "indexed_ready_queue_macros.svh"

module indexed_ready_queue
  import irq_pkg::*;
#(
  parameter int ENTRIES    = 256,
  parameter int EVENT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_handle,
  input  logic [31:0] in_event_mask,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_handle,
  output logic [31:0] out_event,
  output logic        out_queue_empty
);

  // Only handles below 256 can arrive on the port.
  localparam int SLOTS = (ENTRIES < 256) ? ENTRIES : 256;
  localparam int IW    = $clog2(SLOTS);
  localparam int EW    = EVENT_BITS;

  state_t          state_r, state_nxt;
  op_t             op_r;
  logic [7:0]      hnd_r;
  logic [EW-1:0]   ev_r;
  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   tail_r, tail_nxt;
  logic            nonempty_r, nonempty_nxt;
  logic [SLOTS-1:0] flags_r, flags_nxt;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [7:0]      out_handle_r, out_handle_nxt;
  logic [31:0]     out_event_r, out_event_nxt;
  logic            out_empty_r, out_empty_nxt;

  logic            next_we, prev_we, ev_we;
  logic [IW-1:0]   next_waddr, prev_waddr;
  logic [IW-1:0]   next_wdata, prev_wdata;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   nx_rd, pv_rd;
  logic [EW-1:0]   ev_rd;

  logic            accept;
  logic            handle_ok;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   tgt;
  logic            push_ok, push_new, push_link, do_unlink;
  logic [63:0]     ev_wide;
  logic [63:0]     ev_rd_wide;
  logic            empty_pop_shown;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign ev_wide = {32'd0, in_event_mask};

  // Capture the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_opcode);
      hnd_r <= in_handle;
      ev_r  <= ev_wide[EW-1:0];
    end
  end

  assign handle_ok  = ({24'd0, hnd_r} < 32'(ENTRIES));
  assign idx        = hnd_r[IW-1:0];
  assign push_ok    = (op_r == OP_PUSH) && handle_ok && (ev_r != '0);
  assign push_new   = push_ok && !flags_r[idx];
  assign push_link  = push_new && nonempty_r;
  assign do_unlink  = ((op_r == OP_POP) && nonempty_r) ||
                      ((op_r == OP_ERASE) && handle_ok && flags_r[idx]);
  assign tgt        = (op_r == OP_POP) ? head_r : idx;
  assign rd_addr    = tgt;
  assign ev_rd_wide = 64'(ev_rd);

  irq_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (nx_rd)
  );

  irq_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (pv_rd)
  );

  irq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_event_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (idx),
    .wdata (ev_r),
    .raddr (rd_addr),
    .rdata (ev_rd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (push_link) begin
          state_nxt = ST_LINK;
        end else if (do_unlink) begin
          state_nxt = ST_UNLINK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LINK:   state_nxt = ST_IDLE;
      ST_UNLINK: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control, RAM writes and result.
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nonempty_nxt   = nonempty_r;
    flags_nxt      = flags_r;
    next_we        = 1'b0;
    prev_we        = 1'b0;
    ev_we          = 1'b0;
    next_waddr     = idx;
    next_wdata     = head_r;
    prev_waddr     = idx;
    prev_wdata     = tail_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STS_DONE;
    out_handle_nxt = 8'd0;
    out_event_nxt  = 32'd0;
    out_empty_nxt  = !nonempty_r;

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_PUSH: begin
            if (!push_ok) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_NOEFFECT;
            end else begin
              ev_we = 1'b1;
              if (push_new) begin
                flags_nxt[idx] = 1'b1;
                nonempty_nxt   = 1'b1;
                next_we        = 1'b1;
                prev_we        = 1'b1;
                if (!nonempty_r) begin
                  // Single-entry ring points to itself.
                  next_wdata    = idx;
                  prev_wdata    = idx;
                  head_nxt      = idx;
                  tail_nxt      = idx;
                  out_valid_nxt = 1'b1;
                  out_empty_nxt = 1'b0;
                end
              end else begin
                // Already queued: replace event, keep position.
                out_valid_nxt = 1'b1;
              end
            end
          end
          OP_POP: begin
            if (!nonempty_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_EMPTY;
            end
          end
          OP_ERASE: begin
            if (!do_unlink) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_NOEFFECT;
            end
          end
          OP_CLEAR: begin
            flags_nxt     = '0;
            nonempty_nxt  = 1'b0;
            head_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_empty_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_LINK: begin
        // Append after the old tail, close the ring back to head.
        next_we       = 1'b1;
        next_waddr    = tail_r;
        next_wdata    = idx;
        prev_we       = 1'b1;
        prev_waddr    = head_r;
        prev_wdata    = idx;
        tail_nxt      = idx;
        out_valid_nxt = 1'b1;
        out_empty_nxt = 1'b0;
      end
      ST_UNLINK: begin
        flags_nxt[tgt] = 1'b0;
        if (nx_rd == tgt) begin
          nonempty_nxt = 1'b0;
          head_nxt     = '0;
        end else begin
          if (tgt == head_r) begin
            head_nxt = nx_rd;
          end
          if (tgt == tail_r) begin
            tail_nxt = pv_rd;
          end
          next_we    = 1'b1;
          next_waddr = pv_rd;
          next_wdata = nx_rd;
          prev_we    = 1'b1;
          prev_waddr = nx_rd;
          prev_wdata = pv_rd;
        end
        if (op_r == OP_POP) begin
          out_handle_nxt = 8'(tgt);
          out_event_nxt  = ev_rd_wide[31:0];
        end
        out_valid_nxt = 1'b1;
        out_empty_nxt = (nx_rd == tgt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nonempty_r  <= nonempty_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_event_r  <= out_event_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_handle      = out_handle_r;
  assign out_event       = out_event_r;
  assign out_queue_empty = out_empty_r;

  assign empty_pop_shown = out_valid_r && (out_status_r == STS_EMPTY);

  `IRQ_ASSERT_ALWAYS(a_flags_nonempty, clk, rst_n, ((|flags_r) == nonempty_r), "flags vs nonempty")
  `IRQ_ASSERT_IMPLY(a_empty_head_zero, clk, rst_n, !nonempty_r, (head_r == '0), "head not zero")
  `IRQ_ASSERT_IMPLY(a_link_nonempty, clk, rst_n, (state_r == ST_LINK), nonempty_r, "link on empty")
  `IRQ_ASSERT_IMPLY(a_empty_pop, clk, rst_n, empty_pop_shown, out_empty_r, "bad empty pop")
  `IRQ_ASSERT_IMPLY(a_result_busy, clk, rst_n, out_valid, $past(busy), "result without busy")

endmodule
